FILE: rtl/ssrl_pkg.sv
// ============================================================================
// ssrl_pkg
// Shared types and constants of the servo slew-rate limiter.
// ============================================================================
package ssrl_pkg;

    // Channel count and channel address width
    localparam int CHANNELS = 3;
    localparam int CH_W     = 2;

    // Item command codes
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic REG_PULSE_SCALE  = 1'b0;
    localparam logic REG_PULSE_CENTER = 1'b1;

    // Configuration reset values
    localparam logic [11:0] SCALE_RESET  = 12'd800;
    localparam logic [15:0] CENTER_RESET = 16'd2040;

    // Heartbeat slots per period
    localparam logic [3:0] SLOTS = 4'd10;

    // Target range
    localparam logic signed [11:0] TARGET_MIN = -12'sd1024;
    localparam logic signed [11:0] TARGET_MAX = 12'sd1024;

    // Pulse width limits
    localparam logic signed [24:0] CH0_WIDTH_MIN = 25'sd1240;
    localparam logic signed [24:0] CH0_WIDTH_MAX = 25'sd2840;
    localparam logic signed [24:0] WIDTH_FLOOR   = 25'sd0;
    localparam logic signed [24:0] WIDTH_CEIL    = 25'sd65535;

    // Step limit after reset
    localparam logic [6:0] STEP_RESET = 7'd2;

    // Per-channel state word; position is held as 100*pos_q + pos_r, pos_r in 0..99
    typedef struct packed {
        logic signed [11:0] pos_q;
        logic        [6:0]  pos_r;
        logic signed [11:0] tgt;
        logic        [6:0]  step;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        pos_q: 12'sd0,
        pos_r: 7'd0,
        tgt:   12'sd0,
        step:  STEP_RESET
    };

endpackage

FILE: rtl/servo_slew_rate_limiter.sv
// ============================================================================
// servo_slew_rate_limiter
// Three-channel servo slew-rate limiter with per-channel state in a small RAM.
//
// The block takes one word per clock cycle while item_stall is low and returns
// one result word per input word. An accepted word passes through stages 1, 2
// and 3 and the output register; the result is held while the output stalls.
// Channel position, target and step limit live in a synchronous RAM; a word
// reads its channel entry in the accept cycle and writes it back from stage 1,
// with a bypass from that write-back to a following word on the same channel,
// so back-to-back words to one channel run at full rate. The multiply and
// scaling for the pulse width follow in stage 3 and the output register. Enable
// flags are kept in flip-flops and settled in the accept cycle. The user must
// write configuration only while the block is idle; it is not enforced here.
// ============================================================================
module servo_slew_rate_limiter
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,

    // input words
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        cmd,
    input  logic [1:0]  channel,
    input  logic signed [11:0] target,
    input  logic        enable,
    input  logic [6:0]  step_limit,
    input  logic [3:0]  tick_phase,
    input  logic [2:0]  pwm_levels,

    // result words
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  enabled_mask,
    output logic [2:0]  disable_mask,
    output logic        pulse_valid,
    output logic [1:0]  pulse_channel,
    output logic [15:0] pulse_width
);
    import ssrl_pkg::*;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [11:0] scale_reg;
    logic [15:0] center_reg;

    logic [CHANNELS-1:0] req_reg, req_next;
    logic [CHANNELS-1:0] en_reg, en_next;
    logic [CHANNELS-1:0] dis_now;
    logic [CHANNELS-1:0] ent_valid_reg;

    logic            accept;
    logic [3:0]      phase_m;
    logic [3:0]      phase_dec;
    logic            set_hit;
    logic            tick_hit;
    logic [CH_W-1:0] acc_addr;
    logic signed [11:0] tgt_sat;

    // channel RAM
    entry_t          chan_mem [CHANNELS];
    entry_t          rd_data_reg;
    logic            byp_hit_reg;
    entry_t          byp_data_reg;
    logic            init_reg;
    logic            mem_we;
    logic [CH_W-1:0] mem_waddr;
    entry_t          mem_wdata;

    // stage 1
    logic            s1_valid_reg;
    logic            s1_set_reg;
    logic            s1_move_reg;
    logic [CH_W-1:0] s1_addr_reg;
    logic signed [11:0] s1_tgt_reg;
    logic [6:0]      s1_step_reg;
    logic [CHANNELS-1:0] s1_en_reg;
    logic [CHANNELS-1:0] s1_dis_reg;

    // stage 2
    logic            s2_valid_reg;
    logic            s2_pulse_reg;
    logic [CH_W-1:0] s2_ch_reg;
    logic signed [11:0] s2_q_reg;
    logic [CHANNELS-1:0] s2_en_reg;
    logic [CHANNELS-1:0] s2_dis_reg;

    // stage 3
    logic            s3_valid_reg;
    logic            s3_pulse_reg;
    logic [CH_W-1:0] s3_ch_reg;
    logic signed [24:0] s3_prod_reg;
    logic [CHANNELS-1:0] s3_en_reg;
    logic [CHANNELS-1:0] s3_dis_reg;

    // output register
    logic            out_valid_reg;
    logic [CHANNELS-1:0] out_en_reg;
    logic [CHANNELS-1:0] out_dis_reg;
    logic            out_pulse_reg;
    logic [CH_W-1:0] out_ch_reg;
    logic [15:0]     out_width_reg;

    // flow control
    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic adv1, adv2, adv3;

    // stage 1 datapath
    entry_t          cur;
    logic signed [12:0] q_old;
    logic signed [12:0] gap;
    logic signed [12:0] step_s;
    logic            limited;
    logic signed [8:0] r_sum;
    logic signed [8:0] r_fix;
    logic signed [12:0] a_adj;
    logic signed [12:0] a_next;
    logic [6:0]      r_next;
    logic signed [12:0] q_new;
    logic            s1_pulse;

    // output datapath
    logic signed [24:0] prod_adj;
    logic signed [24:0] w_raw;
    logic signed [24:0] w_clamp;

    // ------------------------------------------------------------------
    // Flow control: each stage moves when empty or when the next one moves
    // ------------------------------------------------------------------
    assign out_ready  = !out_valid_reg || !result_stall;
    assign s3_ready   = !s3_valid_reg || out_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign adv1       = s1_valid_reg && s2_ready;
    assign adv2       = s2_valid_reg && s3_ready;
    assign adv3       = s3_valid_reg && out_ready;
    assign item_stall = !s1_ready;
    assign accept     = item_valid && s1_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            center_reg <= CENTER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PULSE_SCALE:  scale_reg  <= cfg_data[11:0];
                REG_PULSE_CENTER: center_reg <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept-cycle decode and enable settling
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_m   = (tick_phase >= SLOTS) ? (tick_phase - SLOTS) : tick_phase;
        phase_dec = phase_m - 4'd1;
        set_hit   = (cmd == CMD_SET) && ({30'd0, channel} < CHANNELS);
        tick_hit  = (cmd == CMD_TICK) && (phase_m != 4'd0)
                    && ({28'd0, phase_m} <= CHANNELS);
        acc_addr  = (cmd == CMD_SET) ? channel[CH_W-1:0] : phase_dec[CH_W-1:0];

        if (target < TARGET_MIN)
            tgt_sat = TARGET_MIN;
        else if (target > TARGET_MAX)
            tgt_sat = TARGET_MAX;
        else
            tgt_sat = target;

        req_next = req_reg;
        en_next  = en_reg;
        dis_now  = '0;
        if (set_hit)
            req_next[acc_addr] = enable;
        if (cmd == CMD_TICK)
        begin
            // request on enables at once; request off waits for a low level
            en_next = req_reg | (en_reg & pwm_levels[CHANNELS-1:0]);
            dis_now = en_reg & ~req_reg & ~pwm_levels[CHANNELS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
            en_reg  <= '0;
        end
        else if (accept)
        begin
            req_reg <= req_next;
            en_reg  <= en_next;
        end
    end

    // ------------------------------------------------------------------
    // Channel RAM: write from stage 1, read at accept
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            chan_mem[mem_waddr] <= mem_wdata;
        if (accept)
            rd_data_reg <= chan_mem[acc_addr];
    end

    // entry valid bits: an unwritten entry reads as its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_valid_reg <= '0;
        else if (mem_we)
            ent_valid_reg[mem_waddr] <= 1'b1;
    end

    // bypass of the write-back that lands in the read cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp_hit_reg  <= mem_we && (mem_waddr == acc_addr);
            byp_data_reg <= mem_wdata;
            init_reg     <= !ent_valid_reg[acc_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (adv1)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_set_reg  <= set_hit;
            s1_move_reg <= tick_hit && en_next[acc_addr];
            s1_addr_reg <= acc_addr;
            s1_tgt_reg  <= tgt_sat;
            s1_step_reg <= step_limit;
            s1_en_reg   <= en_next;
            s1_dis_reg  <= dis_now;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 datapath: slew step and write-back
    // ------------------------------------------------------------------
    always_comb
    begin
        if (byp_hit_reg)
            cur = byp_data_reg;
        else if (init_reg)
            cur = ENTRY_RESET;
        else
            cur = rd_data_reg;

        // truncated whole-unit position
        q_old = {cur.pos_q[11], cur.pos_q}
                + (((cur.pos_q < 0) && (cur.pos_r != 7'd0)) ? 13'sd1 : 13'sd0);
        gap     = {cur.tgt[11], cur.tgt} - q_old;
        step_s  = $signed({6'd0, cur.step});
        limited = (cur.step != 7'd0) && ((gap > step_s) || (-gap > step_s));

        r_sum  = '0;
        r_fix  = '0;
        a_adj  = '0;
        if (limited)
        begin
            // move by the step in hundredths, then renormalize the remainder
            r_sum = (gap > 13'sd0) ? ($signed({2'd0, cur.pos_r}) + $signed({2'd0, cur.step}))
                                   : ($signed({2'd0, cur.pos_r}) - $signed({2'd0, cur.step}));
            if (r_sum < -9'sd100)
            begin
                r_fix = r_sum + 9'sd200;
                a_adj = -13'sd2;
            end
            else if (r_sum < 9'sd0)
            begin
                r_fix = r_sum + 9'sd100;
                a_adj = -13'sd1;
            end
            else if (r_sum >= 9'sd200)
            begin
                r_fix = r_sum - 9'sd200;
                a_adj = 13'sd2;
            end
            else if (r_sum >= 9'sd100)
            begin
                r_fix = r_sum - 9'sd100;
                a_adj = 13'sd1;
            end
            else
            begin
                r_fix = r_sum;
                a_adj = 13'sd0;
            end
            a_next = {cur.pos_q[11], cur.pos_q} + a_adj;
            r_next = r_fix[6:0];
        end
        else
        begin
            // snap whole units onto the target
            a_next = {cur.pos_q[11], cur.pos_q} + gap;
            r_next = cur.pos_r;
        end

        q_new = a_next + (((a_next < 0) && (r_next != 7'd0)) ? 13'sd1 : 13'sd0);

        // channel 0 only reports a changed position
        s1_pulse = s1_move_reg && ((s1_addr_reg != '0) || (gap != 13'sd0));

        mem_we    = adv1 && (s1_set_reg || s1_move_reg);
        mem_waddr = s1_addr_reg;
        mem_wdata = cur;
        if (s1_set_reg)
        begin
            mem_wdata.tgt  = s1_tgt_reg;
            mem_wdata.step = s1_step_reg;
        end
        else
        begin
            mem_wdata.pos_q = a_next[11:0];
            mem_wdata.pos_r = r_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: registered quotient
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv1)
            s2_valid_reg <= 1'b1;
        else if (adv2)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s2_pulse_reg <= s1_pulse;
            s2_ch_reg    <= s1_addr_reg;
            s2_q_reg     <= q_new[11:0];
            s2_en_reg    <= s1_en_reg;
            s2_dis_reg   <= s1_dis_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: position times scale
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv2)
            s3_valid_reg <= 1'b1;
        else if (adv3)
            s3_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s3_pulse_reg <= s2_pulse_reg;
            s3_ch_reg    <= s2_ch_reg;
            s3_prod_reg  <= $signed({{13{s2_q_reg[11]}}, s2_q_reg})
                            * $signed({13'd0, scale_reg});
            s3_en_reg    <= s2_en_reg;
            s3_dis_reg   <= s2_dis_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output datapath: truncating divide by 1024, offset and clamp
    // ------------------------------------------------------------------
    always_comb
    begin
        prod_adj = s3_prod_reg + ((s3_prod_reg < 0) ? 25'sd1023 : 25'sd0);
        w_raw    = (prod_adj >>> 10) + $signed({9'd0, center_reg});
        if (s3_ch_reg == '0)
        begin
            if (w_raw < CH0_WIDTH_MIN)
                w_clamp = CH0_WIDTH_MIN;
            else if (w_raw > CH0_WIDTH_MAX)
                w_clamp = CH0_WIDTH_MAX;
            else
                w_clamp = w_raw;
        end
        else
        begin
            if (w_raw < WIDTH_FLOOR)
                w_clamp = WIDTH_FLOOR;
            else if (w_raw > WIDTH_CEIL)
                w_clamp = WIDTH_CEIL;
            else
                w_clamp = w_raw;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv3)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            out_en_reg    <= s3_en_reg;
            out_dis_reg   <= s3_dis_reg;
            out_pulse_reg <= s3_pulse_reg;
            out_ch_reg    <= s3_pulse_reg ? s3_ch_reg : '0;
            out_width_reg <= s3_pulse_reg ? w_clamp[15:0] : 16'd0;
        end
    end

    assign result_valid  = out_valid_reg;
    assign enabled_mask  = out_en_reg;
    assign disable_mask  = out_dis_reg;
    assign pulse_valid   = out_pulse_reg;
    assign pulse_channel = out_ch_reg;
    assign pulse_width   = out_width_reg;

endmodule

FILE: verif/tb.sv
// ============================================================================
// tb
// Self-checking bench for the three-channel servo slew-rate limiter.
//
// Set and tick words are driven through the valid/stall input channel while
// result words are taken with random back-pressure. A scoreboard models each
// channel's target, step limit, enable request, enabled flag and position.
// It predicts one result per accepted word and compares each arriving result
// field by field. The run covers several scale and center settings, the
// extremes among them, along with edge-case words and long randomized
// heartbeat sequences.
// ============================================================================
module tb;

    import ssrl_pkg::*;

    localparam int POS_SCALE     = 100;      // position is held in hundredths
    localparam int FULL_DEFLECT  = 512;      // position units for full scale
    localparam int HOLD_CYCLES   = 80;       // long output hold-off
    localparam int RANDOM_WORDS  = 300;      // random words per setting
    localparam int SETTINGS_N    = 5;
    localparam int CYCLE_LIMIT   = 200000;

    // One expected or observed result word
    typedef struct packed {
        logic [2:0]  en_mask;
        logic [2:0]  dis_mask;
        logic        pv;
        logic [1:0]  pch;
        logic [15:0] pw;
    } servo_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: channel state mirror plus queue of expected result words
    // ------------------------------------------------------------------------
    class servo_scoreboard;
        int            pos[CHANNELS];
        int            tgt[CHANNELS];
        int            step_lim[CHANNELS];
        bit            req[CHANNELS];
        bit            on[CHANNELS];
        int            scale;
        int            center;
        servo_result_t expected_q[$];
        int            errors;

        function new();
            scale  = int'(SCALE_RESET);
            center = int'(CENTER_RESET);
            errors = 0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                pos[k]      = 0;
                tgt[k]      = 0;
                step_lim[k] = int'(STEP_RESET);
                req[k]      = 1'b0;
                on[k]       = 1'b0;
            end
        endfunction

        function void configure(input logic idx, input logic [15:0] value);
            if (idx == REG_PULSE_SCALE)
                scale = int'(value[11:0]);
            else
                center = int'(value);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the mirror by one accepted word and queue its result
        function void note_word(input logic c, input logic [1:0] ch,
                                input logic signed [11:0] tg, input logic en,
                                input logic [6:0] st, input logic [3:0] ph,
                                input logic [2:0] lv);
            servo_result_t r;
            int            t;
            int            d;
            int            w;
            int            slot;

            r = '0;
            if (c == CMD_SET)
            begin
                // out-of-range channel is dropped, result still returned
                if (ch < CHANNELS)
                begin
                    t = tg;
                    if (t < TARGET_MIN)
                        t = TARGET_MIN;
                    if (t > TARGET_MAX)
                        t = TARGET_MAX;
                    tgt[ch]      = t;
                    req[ch]      = en;
                    step_lim[ch] = int'(st);
                end
            end
            else
            begin
                slot = int'(ph % SLOTS);
                // enable settles first; disable waits for a low PWM level
                for (int k = 0; k < CHANNELS; k++)
                begin
                    if (on[k] != req[k])
                    begin
                        if (req[k])
                            on[k] = 1'b1;
                        else if (!lv[k])
                        begin
                            on[k]         = 1'b0;
                            r.dis_mask[k] = 1'b1;
                        end
                    end
                end
                // channel in its own slot moves and emits a width
                for (int k = 0; k < CHANNELS; k++)
                begin
                    if (on[k] && slot == k + 1)
                    begin
                        d = tgt[k] - pos[k] / POS_SCALE;
                        if (step_lim[k] > 0 && (d > step_lim[k] || -d > step_lim[k]))
                            d = (d > 0) ? step_lim[k] : -step_lim[k];
                        else
                            d = d * POS_SCALE;
                        // channel 0 writes only on a change of position
                        if (!(k == 0 && d == 0))
                        begin
                            pos[k] += d;
                            w = ((pos[k] / POS_SCALE) * scale / 2) / FULL_DEFLECT + center;
                            if (k == 0)
                            begin
                                if (w < CH0_WIDTH_MIN)
                                    w = CH0_WIDTH_MIN;
                                else if (w > CH0_WIDTH_MAX)
                                    w = CH0_WIDTH_MAX;
                            end
                            else
                            begin
                                if (w < WIDTH_FLOOR)
                                    w = WIDTH_FLOOR;
                                else if (w > WIDTH_CEIL)
                                    w = WIDTH_CEIL;
                            end
                            r.pv  = 1'b1;
                            r.pch = 2'(k);
                            r.pw  = w[15:0];
                        end
                    end
                end
            end
            for (int k = 0; k < CHANNELS; k++)
                r.en_mask[k] = on[k];
            expected_q.push_back(r);
        endfunction

        // Compare one arriving result word with the oldest expectation
        function void check_word(input servo_result_t got);
            servo_result_t exp_r;

            if (expected_q.size() == 0)
            begin
                $error("result word with no expectation pending");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.en_mask !== exp_r.en_mask)
            begin
                $error("enabled_mask: expected %0d, actual %0d", exp_r.en_mask, got.en_mask);
                errors++;
            end
            if (got.dis_mask !== exp_r.dis_mask)
            begin
                $error("disable_mask: expected %0d, actual %0d", exp_r.dis_mask, got.dis_mask);
                errors++;
            end
            if (got.pv !== exp_r.pv)
            begin
                $error("pulse_valid: expected %0d, actual %0d", exp_r.pv, got.pv);
                errors++;
            end
            if (got.pch !== exp_r.pch)
            begin
                $error("pulse_channel: expected %0d, actual %0d", exp_r.pch, got.pch);
                errors++;
            end
            if (got.pw !== exp_r.pw)
            begin
                $error("pulse_width: expected %0d, actual %0d", exp_r.pw, got.pw);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [15:0]        cfg_data;
    logic               item_valid;
    logic               item_stall;
    logic               cmd;
    logic [1:0]         channel;
    logic signed [11:0] target;
    logic               enable;
    logic [6:0]         step_limit;
    logic [3:0]         tick_phase;
    logic [2:0]         pwm_levels;
    logic               result_valid;
    logic               result_stall;
    logic [2:0]         enabled_mask;
    logic [2:0]         disable_mask;
    logic               pulse_valid;
    logic [1:0]         pulse_channel;
    logic [15:0]        pulse_width;

    int                 tx_idle_pct;
    int                 rx_idle_pct;
    logic               hold_req;
    int                 cycles;
    servo_result_t      observed;

    servo_scoreboard    board = new;

    servo_slew_rate_limiter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .cmd           (cmd),
        .channel       (channel),
        .target        (target),
        .enable        (enable),
        .step_limit    (step_limit),
        .tick_phase    (tick_phase),
        .pwm_levels    (pwm_levels),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .enabled_mask  (enabled_mask),
        .disable_mask  (disable_mask),
        .pulse_valid   (pulse_valid),
        .pulse_channel (pulse_channel),
        .pulse_width   (pulse_width)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle count and run limit
    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output back-pressure, with an occasional long hold-off
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            observed.en_mask  = enabled_mask;
            observed.dis_mask = disable_mask;
            observed.pv       = pulse_valid;
            observed.pch      = pulse_channel;
            observed.pw       = pulse_width;
            board.check_word(observed);
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks; each starts and ends at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_word(input logic c, input logic [1:0] ch,
                             input logic signed [11:0] tg, input logic en,
                             input logic [6:0] st, input logic [3:0] ph,
                             input logic [2:0] lv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        cmd        <= c;
        channel    <= ch;
        target     <= tg;
        enable     <= en;
        step_limit <= st;
        tick_phase <= ph;
        pwm_levels <= lv;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.note_word(c, ch, tg, en, st, ph, lv);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.configure(idx, value);
    endtask

    // Hold the input side quiet until every expected word has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic               c;
        logic [1:0]         ch;
        logic signed [11:0] tg;
        logic               en;
        logic [6:0]         st;
        logic [3:0]         ph;
        logic [2:0]         lv;
        int                 beat;
        int                 roll;
        logic [11:0]        scale_set[SETTINGS_N];
        logic [15:0]        center_set[SETTINGS_N];

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_PULSE_SCALE;
        cfg_data    = '0;
        item_valid  = 1'b0;
        cmd         = CMD_SET;
        channel     = '0;
        target      = '0;
        enable      = 1'b0;
        step_limit  = '0;
        tick_phase  = '0;
        pwm_levels  = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 7;
        rx_idle_pct = 77;
        beat        = 0;

        // setting 0 keeps the reset values; extremes follow, then a random pair
        scale_set[0] = SCALE_RESET;  center_set[0] = CENTER_RESET;
        scale_set[1] = 12'd4095;     center_set[1] = 16'd65535;
        scale_set[2] = 12'd4095;     center_set[2] = 16'd0;
        scale_set[3] = 12'd0;        center_set[3] = 16'd32768;
        scale_set[4] = 12'($urandom_range(4095));
        center_set[4] = 16'($urandom_range(65535));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words on reset settings
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd1,  3'd0); // nothing enabled
        send_word(CMD_SET,  2'd0, 12'sd1024, 1'b1, 7'd0,   4'd0,  3'd0); // no step limit
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd1,  3'd0); // snap to target
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd1,  3'd0); // no move, no pulse
        send_word(CMD_SET,  2'd0, 12'h800,   1'b1, 7'd127, 4'd0,  3'd0); // target saturates low
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd11, 3'd0); // phase wraps to 1
        send_word(CMD_SET,  2'd1, 12'sd2047, 1'b1, 7'd0,   4'd0,  3'd0); // target saturates high
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd2,  3'd0);
        send_word(CMD_SET,  2'd2, -12'sd1024, 1'b1, 7'd1,  4'd0,  3'd0); // smallest step
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd3,  3'd0);
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd13, 3'd0);
        send_word(CMD_SET,  2'd3, 12'sd5,    1'b1, 7'd5,   4'd0,  3'd0); // channel out of range
        send_word(CMD_SET,  2'd0, 12'sd0,    1'b0, 7'd2,   4'd0,  3'd0);
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd0,  3'd7); // level high, stays on
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd5,  3'd6); // ch0 now disabled
        send_word(CMD_SET,  2'd1, 12'sd0,    1'b0, 7'd0,   4'd0,  3'd0);
        send_word(CMD_SET,  2'd2, 12'sd0,    1'b0, 7'd0,   4'd0,  3'd0);
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd15, 3'd0); // two disables at once
        send_word(CMD_TICK, 2'd0, 12'sd0,    1'b0, 7'd0,   4'd9,  3'd0);

        for (int s = 0; s < SETTINGS_N; s++)
        begin
            if (s < 2)
            begin
                tx_idle_pct = 7;
                rx_idle_pct = 77;
            end
            else if (s < 4)
            begin
                tx_idle_pct = 77;
                rx_idle_pct = 7;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (s > 0)
            begin
                wait_drained();
                write_reg(REG_PULSE_SCALE, 16'(scale_set[s]));
                write_reg(REG_PULSE_CENTER, center_set[s]);

                // full deflection both ways on every channel
                for (int j = 0; j < 2; j++)
                begin
                    for (int k = 0; k < CHANNELS; k++)
                        send_word(CMD_SET, 2'(k), (j == 0) ? TARGET_MAX : TARGET_MIN,
                                  1'b1, 7'd0, 4'd0, 3'd0);
                    for (int k = 1; k <= CHANNELS; k++)
                        send_word(CMD_TICK, 2'd0, 12'sd0, 1'b0, 7'd0, 4'(k), 3'd0);
                end
            end

            // Random words: mostly heartbeat ticks, some sets, some stray phases
            for (int n = 0; n < RANDOM_WORDS; n++)
            begin
                if (n == 40 && (s == 0 || s == 4))
                    hold_req = 1'b1;
                roll = $urandom_range(99);
                ch = 2'($urandom_range(3));
                tg = 12'($urandom);
                en = 1'($urandom);
                st = 7'($urandom);
                ph = 4'($urandom);
                lv = 3'($urandom);
                if (roll < 15)
                begin
                    c = CMD_SET;
                    ch = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
                    if ($urandom_range(9) != 0)
                        tg = 12'(int'($urandom_range(2048)) - 1024);
                    en = ($urandom_range(4) != 0);
                    if ($urandom_range(7) == 0)
                        st = '0;
                end
                else if (roll < 22)
                    c = CMD_TICK;
                else
                begin
                    c = CMD_TICK;
                    beat = (beat + 1) % 10;
                    ph = 4'(beat);
                end
                send_word(c, ch, tg, en, st, ph, lv);
            end
        end

        // Drain and let any stray word show up
        wait_drained();
        repeat (20) @(negedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ssrl_pkg.sv
rtl/servo_slew_rate_limiter.sv
verif/tb.sv
